/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, operation and status codes, and control structs for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OP_W          = 3;
    localparam int WORD_W        = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // count as shown on the result port when the queue is full
    localparam logic [ENTRY_COUNT_W-1:0] FULL_COUNT = ENTRY_COUNT_W'(DEPTH);

    typedef struct packed {
        logic load_item;   // capture the incoming transaction
        logic exec;        // apply the operation to the ring
        logic rd_update;   // refresh an end cache from the store read
        logic load_out;    // move the result into the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_read;   // a remove leaves a new end word to fetch
    } t_dp_status;

endpackage

/* sv/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the double-ended queue: input handshake, operation steps
// and output valid.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_read ? S_READ : S_DONE;
            end
            S_READ: begin
                o_cmd.rd_update = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/deq_datapath.sv */
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, head index, count, cached end words and result register.
// ----------------------------------------------------------------------------
module deq_datapath import deq_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctrl_cmd                  i_cmd,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [WORD_W-1:0]   i_data_in,
    output t_dp_status                 o_status,
    output logic signed [WORD_W-1:0]   o_removed_value,
    output logic signed [WORD_W-1:0]   o_first_value,
    output logic signed [WORD_W-1:0]   o_last_value,
    output logic [ENTRY_COUNT_W-1:0]   o_entry_count,
    output logic [STATUS_W-1:0]        o_status_code
);

    // ring position idx + off, both below DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, idx} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   r_rd_data;

    logic [OP_W-1:0]     r_op;
    logic [WORD_W-1:0]   r_data;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [WORD_W-1:0]   r_first;
    logic [WORD_W-1:0]   r_last;
    logic [WORD_W-1:0]   r_removed;
    logic [STATUS_W-1:0] r_status;

    logic                is_full, is_empty, is_single;
    logic [IDX_W-1:0]    idx_prev_head, idx_next_head, idx_tail_slot, idx_new_last;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    logic                wr_en, rd_en;

    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign is_single = (r_count == CNT_W'(1));

    assign idx_prev_head = wrap_add(r_head, IDX_W'(DEPTH - 1));
    assign idx_next_head = wrap_add(r_head, IDX_W'(1));
    assign idx_tail_slot = wrap_add(r_head, IDX_W'(r_count));
    assign idx_new_last  = wrap_add(r_head, IDX_W'(r_count - CNT_W'(2)));

    // a remove that leaves at least one word must fetch the new end word
    assign o_status.need_read = (r_op inside {OP_REM_FRONT, OP_REM_BACK})
                                && !is_empty && !is_single;

    assign wr_en   = i_cmd.exec && !is_full
                     && ((r_op == OP_ADD_FRONT) || (r_op == OP_ADD_BACK));
    assign wr_addr = (r_op == OP_ADD_FRONT) ? idx_prev_head : idx_tail_slot;
    assign rd_en   = i_cmd.exec && o_status.need_read;
    assign rd_addr = (r_op == OP_REM_FRONT) ? idx_next_head : idx_new_last;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_operation;
            r_data <= i_data_in;
        end
    end

    // queue state and end-word caches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else if (i_cmd.exec) begin
            case (r_op)
                OP_ADD_FRONT: begin
                    if (!is_full) begin
                        r_head  <= idx_prev_head;
                        r_count <= r_count + CNT_W'(1);
                        r_first <= r_data;
                        if (is_empty) r_last <= r_data;
                    end
                end
                OP_ADD_BACK: begin
                    if (!is_full) begin
                        r_count <= r_count + CNT_W'(1);
                        r_last  <= r_data;
                        if (is_empty) r_first <= r_data;
                    end
                end
                OP_REM_FRONT: begin
                    if (!is_empty) begin
                        r_head  <= idx_next_head;
                        r_count <= r_count - CNT_W'(1);
                        if (is_single) begin
                            r_first <= '0;
                            r_last  <= '0;
                        end
                    end
                end
                OP_REM_BACK: begin
                    if (!is_empty) begin
                        r_count <= r_count - CNT_W'(1);
                        if (is_single) begin
                            r_first <= '0;
                            r_last  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.rd_update) begin
            if (r_op == OP_REM_FRONT) begin
                r_first <= r_rd_data;
            end else begin
                r_last <= r_rd_data;
            end
        end
    end

    // removed word and status, decided from the state before the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_removed <= '0;
            r_status  <= ST_DONE;
            case (r_op)
                OP_ADD_FRONT, OP_ADD_BACK: begin
                    if (is_full) r_status <= ST_FULL;
                end
                OP_REM_FRONT: begin
                    if (is_empty) r_status <= ST_EMPTY;
                    else          r_removed <= r_first;
                end
                OP_REM_BACK: begin
                    if (is_empty) r_status <= ST_EMPTY;
                    else          r_removed <= r_last;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_removed_value <= r_removed;
            o_first_value   <= r_first;
            o_last_value    <= r_last;
            o_entry_count   <= ENTRY_COUNT_W'(r_count);
            o_status_code   <= r_status;
        end
    end

endmodule

/* sv/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transaction: add front, add back, remove front, remove back or read only
//   (unused codes act as read only). i_data_in matters for adds only.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   per operation: removed word, first and last word (zero when empty),
//   entry count and status (done, add refused when full, remove refused
//   when empty). A refused operation leaves the queue unchanged.
// Sequencing:
//   One operation is in flight at a time. After the accepting edge the
//   controller applies it; when a remove must fetch the new end word from
//   the store (its single registered read port), it then refreshes that
//   end word from the read; last it loads the result register. A new
//   operation is taken only once the result of the last one has been
//   loaded, and loading waits while an earlier result is still stalled.
//   The result register decouples the sides: the next operation is
//   accepted and applied while an earlier result is still stalled.
// Reset:
//   Synchronous, active low. The queue comes up empty, no result pending.
//   Store contents are not cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [WORD_W-1:0]   i_data_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [WORD_W-1:0]   o_removed_value,
    output logic signed [WORD_W-1:0]   o_first_value,
    output logic signed [WORD_W-1:0]   o_last_value,
    output logic [ENTRY_COUNT_W-1:0]   o_entry_count,
    output logic [STATUS_W-1:0]        o_status
);

    t_ctrl_cmd  cmd;     // controller -> datapath step commands
    t_dp_status status;  // datapath -> controller flags

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    deq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_data_in       (i_data_in),
        .o_status        (status),
        .o_removed_value (o_removed_value),
        .o_first_value   (o_first_value),
        .o_last_value    (o_last_value),
        .o_entry_count   (o_entry_count),
        .o_status_code   (o_status)
    );

endmodule

/* sv/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [WORD_W-1:0]   o_removed_value,
    input logic signed [WORD_W-1:0]   o_first_value,
    input logic signed [WORD_W-1:0]   o_last_value,
    input logic [ENTRY_COUNT_W-1:0]   o_entry_count,
    input logic [STATUS_W-1:0]        o_status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_removed_value)
            && $stable(o_first_value) && $stable(o_last_value)
            && $stable(o_entry_count) && $stable(o_status))
        else $error("stalled result changed");

    // one operation in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_entry_count == FULL_COUNT)
        else $error("full refusal with queue not full");

    a_empty_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY)
            |-> (o_entry_count == '0) && (o_removed_value == '0))
        else $error("empty refusal with words held or a removed word");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_entry_count == '0)
            |-> (o_first_value == '0) && (o_last_value == '0))
        else $error("empty queue shows nonzero end words");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
